/* sv/rsbt_pkg.sv */
// Shared types and constants of the resource state barrier tracker.
// Holds request codes, barrier kinds, stream layout and table interface structs.
// No dependencies.
`default_nettype none

package rsbt_pkg;

	// request opcodes, carried in s_axis_tuser
	typedef enum logic [1:0] {
		OP_DECLARE = 2'd0,
		OP_USE     = 2'd1,
		OP_FINISH  = 2'd2
	} op_e;

	// barrier kinds, carried in m_axis_tuser
	typedef enum logic [1:0] {
		KIND_NONE       = 2'd0,
		KIND_TRANSITION = 2'd1,
		KIND_UAV        = 2'd2
	} kind_e;

	// access codes of a use request
	localparam logic [1:0] ACC_READ       = 2'd0;
	localparam logic [1:0] ACC_WRITE      = 2'd1;
	localparam logic [1:0] ACC_READ_WRITE = 2'd2;

	localparam int unsigned OP_W    = 2;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned RES_W   = 6;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned ACC_W   = 2;

	localparam logic [WORD_W-1:0] UAV_MASK_RESET = 32'd8;

	// request tdata layout, lowest bit first
	localparam int unsigned IN_TDATA_W   = 80;
	localparam int unsigned IN_RES_LO    = 0;
	localparam int unsigned IN_STATE_LO  = 6;
	localparam int unsigned IN_FINAL_LO  = 38;
	localparam int unsigned IN_HASFIN_B  = 70;
	localparam int unsigned IN_AUTO_B    = 71;
	localparam int unsigned IN_ACC_LO    = 72;

	// result tdata layout, lowest bit first
	localparam int unsigned OUT_TDATA_W  = 72;
	localparam int unsigned OUT_PAD_W    = 2;

	// table update, already qualified by the stage advancing
	typedef struct packed {
		logic decl;          // load entry, clear history
		logic use_upd;       // tracked use: store state, update history
		logic final_wanted;
		logic tracked;
		logic uav;
		logic uav_wr;
	} tbl_wr_t;

	// per-entry flags read at the stage-1 address
	typedef struct packed {
		logic final_wanted;
		logic tracked;
		logic prior_uav;
		logic prior_uav_wr;
	} tbl_flags_t;

endpackage

`default_nettype wire

/* sv/resource_state_barrier_tracker.sv */
// Resource state barrier tracker: an accepted request waits in stage 1, then its result
// enters the result register (table read registered on accept, decision stored on advance);
// throughput one request per cycle; input stalls once stage 1 waits behind a held result.
// Reset clears the handshake state, the mask register (to 8) and all entry flags;
// state memories are not cleared: an entry is read for a result only after a declare.
// Depends on rsbt_pkg and rsbt_table.
`default_nettype none

module resource_state_barrier_tracker #(
	parameter int unsigned NUM_RESOURCES = 64,
	parameter int unsigned STATE_BITS    = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: uav_state_mask
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	// requests
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// resource_index[5:0], state_word[37:6], final_state_word[69:38], has_final[70],
	// auto_barriers[71], access[73:72], zero pad[79:74]
	input  wire logic [79:0] s_axis_tdata,
	// opcode[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	// results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// barrier_resource[5:0], state_before[37:6], state_after[69:38], zero pad[71:70]
	output logic [71:0]      m_axis_tdata,
	// barrier_kind[1:0]
	output logic [1:0]       m_axis_tuser
);

	localparam int unsigned IDX_W = $clog2(NUM_RESOURCES);
	localparam logic [STATE_BITS-1:0] MASK_RESET = STATE_BITS'(rsbt_pkg::UAV_MASK_RESET);

	// ---------------------------------------------------------------------------
	// Configuration: unordered-access mask, kept at the internal state width
	// ---------------------------------------------------------------------------
	logic [STATE_BITS-1:0] uav_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uav_mask_q <= MASK_RESET;
		end else if (cfg_wr_en) begin
			uav_mask_q <= STATE_BITS'(cfg_wr_data);
		end
	end

	// ---------------------------------------------------------------------------
	// Handshake. Stage 1 holds the request while the table read comes back; the
	// result register parts the output side, so a request can be taken while a
	// finished result still waits.
	// ---------------------------------------------------------------------------
	logic s1_valid_q, out_valid_q;
	logic in_acc, s1_adv;

	assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Stage 1 payload: unpack the request on accept
	// ---------------------------------------------------------------------------
	rsbt_pkg::op_e                   op_s1;
	logic [rsbt_pkg::RES_W-1:0]      idx_s1;
	logic [STATE_BITS-1:0]           st_s1, fin_s1;
	logic                            has_final_s1, auto_s1;
	logic [rsbt_pkg::ACC_W-1:0]      acc_s1;
	logic [rsbt_pkg::RES_W-1:0]      in_idx;

	assign in_idx = s_axis_tdata[rsbt_pkg::IN_RES_LO +: rsbt_pkg::RES_W];

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1        <= rsbt_pkg::op_e'(s_axis_tuser);
			idx_s1       <= in_idx;
			st_s1        <= STATE_BITS'(s_axis_tdata[rsbt_pkg::IN_STATE_LO +: rsbt_pkg::WORD_W]);
			fin_s1       <= STATE_BITS'(s_axis_tdata[rsbt_pkg::IN_FINAL_LO +: rsbt_pkg::WORD_W]);
			has_final_s1 <= s_axis_tdata[rsbt_pkg::IN_HASFIN_B];
			auto_s1      <= s_axis_tdata[rsbt_pkg::IN_AUTO_B];
			acc_s1       <= s_axis_tdata[rsbt_pkg::IN_ACC_LO +: rsbt_pkg::ACC_W];
		end
	end

	// ---------------------------------------------------------------------------
	// Resource table
	// ---------------------------------------------------------------------------
	rsbt_pkg::tbl_wr_t     wr_d, tbl_wr;
	rsbt_pkg::tbl_flags_t  flags;
	logic [STATE_BITS-1:0] cur_state, final_state;
	logic [IDX_W-1:0]      addr_s1;

	assign addr_s1 = IDX_W'(idx_s1);
	// commit the update only on the edge the request leaves stage 1
	assign tbl_wr  = s1_adv ? wr_d : '0;

	rsbt_table #(
		.NUM_RESOURCES (NUM_RESOURCES),
		.STATE_BITS    (STATE_BITS)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (in_acc),
		.rd_addr     (IDX_W'(in_idx)),
		.wr          (tbl_wr),
		.wr_addr     (addr_s1),
		.wr_state    (st_s1),
		.wr_final    (fin_s1),
		.flag_addr   (addr_s1),
		.cur_state   (cur_state),
		.final_state (final_state),
		.flags       (flags)
	);

	// ---------------------------------------------------------------------------
	// Barrier decision
	// ---------------------------------------------------------------------------
	rsbt_pkg::kind_e            kind_d;
	logic [rsbt_pkg::RES_W-1:0] res_d;
	logic [STATE_BITS-1:0]      before_d, after_d;
	logic                       in_range, uav, writes;

	assign in_range = 32'(idx_s1) < 32'(NUM_RESOURCES);

	always_comb begin
		kind_d   = rsbt_pkg::KIND_NONE;
		res_d    = '0;
		before_d = '0;
		after_d  = '0;
		wr_d     = '0;
		uav      = |(st_s1 & uav_mask_q);
		writes   = acc_s1 inside {rsbt_pkg::ACC_WRITE, rsbt_pkg::ACC_READ_WRITE};
		if (s1_valid_q && in_range) begin
			case (op_s1)
				rsbt_pkg::OP_DECLARE: begin
					// load entry, clear its history
					wr_d.decl         = 1'b1;
					wr_d.final_wanted = has_final_s1;
					wr_d.tracked      = auto_s1;
				end
				rsbt_pkg::OP_USE: begin
					if (flags.tracked) begin
						wr_d.use_upd = 1'b1;
						wr_d.uav     = uav;
						wr_d.uav_wr  = uav && writes;
						if (cur_state != st_s1) begin
							kind_d   = rsbt_pkg::KIND_TRANSITION;
							res_d    = idx_s1;
							before_d = cur_state;
							after_d  = st_s1;
						end else if (flags.prior_uav && (flags.prior_uav_wr || writes) && uav) begin
							kind_d = rsbt_pkg::KIND_UAV;
							res_d  = idx_s1;
						end
					end
				end
				rsbt_pkg::OP_FINISH: begin
					// closing transition; table stays as it is
					if (flags.tracked && flags.final_wanted && (cur_state != final_state)) begin
						kind_d   = rsbt_pkg::KIND_TRANSITION;
						res_d    = idx_s1;
						before_d = cur_state;
						after_d  = final_state;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------------------
	rsbt_pkg::kind_e             out_kind_q;
	logic [rsbt_pkg::RES_W-1:0]  out_res_q;
	logic [rsbt_pkg::WORD_W-1:0] out_before_q, out_after_q;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_kind_q   <= kind_d;
			out_res_q    <= res_d;
			out_before_q <= rsbt_pkg::WORD_W'(before_d);
			out_after_q  <= rsbt_pkg::WORD_W'(after_d);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {{rsbt_pkg::OUT_PAD_W{1'b0}}, out_after_q, out_before_q, out_res_q};

	// ---------------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------------
	// a transition always moves to a different state
	a_trans_differs: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && (kind_d == rsbt_pkg::KIND_TRANSITION)) |-> (before_d != after_d))
		else $error("transition barrier with equal before and after state");

	// every request leaving stage 1 shows up as a result next cycle
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> m_axis_tvalid)
		else $error("request left stage 1 without a result");

	// a no-barrier result carries no resource and no states
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == rsbt_pkg::KIND_NONE)) |->
		(m_axis_tdata == '0))
		else $error("no-barrier result with nonzero payload");

	// table updates happen only as a request leaves stage 1
	a_wr_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(tbl_wr.decl || tbl_wr.use_upd) |-> (s1_adv && in_range))
		else $error("table update outside a stage-1 advance");

endmodule

`default_nettype wire

/* sv/rsbt_table.sv */
// Resource table: current and final state memories plus per-entry flag registers.
// Registered memory read with write-to-read bypass; flags read from flops.
// Depends on rsbt_pkg.
`default_nettype none

module rsbt_table #(
	parameter int unsigned NUM_RESOURCES = 64,
	parameter int unsigned STATE_BITS    = 32,
	localparam int unsigned IDX_W        = $clog2(NUM_RESOURCES)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   rd_en,
	input  wire logic [IDX_W-1:0]       rd_addr,
	input  wire rsbt_pkg::tbl_wr_t      wr,
	input  wire logic [IDX_W-1:0]       wr_addr,
	input  wire logic [STATE_BITS-1:0]  wr_state,
	input  wire logic [STATE_BITS-1:0]  wr_final,
	input  wire logic [IDX_W-1:0]       flag_addr,
	output logic [STATE_BITS-1:0]       cur_state,
	output logic [STATE_BITS-1:0]       final_state,
	output rsbt_pkg::tbl_flags_t        flags
);

	logic [STATE_BITS-1:0]    cur_mem [NUM_RESOURCES];
	logic [STATE_BITS-1:0]    fin_mem [NUM_RESOURCES];
	logic [STATE_BITS-1:0]    cur_rd_q, fin_rd_q, cur_byp_q, fin_byp_q;
	logic                     cur_hit_q, fin_hit_q;
	logic [NUM_RESOURCES-1:0] fw_q, trk_q, pua_q, puw_q;
	logic                     cur_we;

	assign cur_we = wr.decl | wr.use_upd;

	always_ff @(posedge clk) begin
		if (cur_we) begin
			cur_mem[wr_addr] <= wr_state;
		end
		if (wr.decl) begin
			fin_mem[wr_addr] <= wr_final;
		end
		if (rd_en) begin
			cur_rd_q  <= cur_mem[rd_addr];
			fin_rd_q  <= fin_mem[rd_addr];
			cur_byp_q <= wr_state;
			fin_byp_q <= wr_final;
		end
	end

	// a write landing on the edge of the read wins over the stale memory word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_hit_q <= 1'b0;
			fin_hit_q <= 1'b0;
		end else if (rd_en) begin
			cur_hit_q <= cur_we && (wr_addr == rd_addr);
			fin_hit_q <= wr.decl && (wr_addr == rd_addr);
		end
	end

	assign cur_state   = cur_hit_q ? cur_byp_q : cur_rd_q;
	assign final_state = fin_hit_q ? fin_byp_q : fin_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= '0;
			trk_q <= '0;
			pua_q <= '0;
			puw_q <= '0;
		end else if (wr.decl) begin
			fw_q[wr_addr]  <= wr.final_wanted;
			trk_q[wr_addr] <= wr.tracked;
			pua_q[wr_addr] <= 1'b0;
			puw_q[wr_addr] <= 1'b0;
		end else if (wr.use_upd) begin
			pua_q[wr_addr] <= wr.uav;
			puw_q[wr_addr] <= wr.uav_wr;
		end
	end

	assign flags.final_wanted = fw_q[flag_addr];
	assign flags.tracked      = trk_q[flag_addr];
	assign flags.prior_uav    = pua_q[flag_addr];
	assign flags.prior_uav_wr = puw_q[flag_addr];

endmodule

`default_nettype wire
